// ===== hw/rtl/hcmm_pkg.sv =====
// Shared types and constants for the handheld console memory-map bus.
// No dependencies; imported by handheld_console_memory_map_bus.
package hcmm_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_rsel;

    // bus operation codes
    localparam t_op OP_READ  = 2'd0;
    localparam t_op OP_WRITE = 2'd1;
    localparam t_op OP_LOAD  = 2'd2;
    localparam t_op OP_NONE  = 2'd3;

    // read data source for a finished transfer
    localparam t_rsel RSEL_ZERO = 2'd0;
    localparam t_rsel RSEL_FF   = 2'd1;
    localparam t_rsel RSEL_ROM  = 2'd2;
    localparam t_rsel RSEL_RAM  = 2'd3;

    localparam logic [15:0] ADDR_ECHO_END  = 16'hFDFF;
    localparam logic [15:0] ADDR_HOLE_LO   = 16'hFEA0;
    localparam logic [15:0] ADDR_IO_LO     = 16'hFF00;
    localparam logic [15:0] ADDR_JOYPAD    = 16'hFF00;
    localparam logic [15:0] ADDR_DIV       = 16'hFF04;
    localparam logic [7:0]  BYTE_FF        = 8'hFF;
    localparam logic [31:0] CYCLES_PER_ACC = 32'd4;

    localparam int ROM_AW = 15;
    localparam int RAM_AW = 15;

endpackage

// ===== hw/rtl/handheld_console_memory_map_bus.sv =====
// Handheld console memory-map bus: ROM memory plus one RAM memory for all
// writable regions, cycle counter and a two-stage result path.
// Depends on hcmm_pkg.
//
// Result path: stage 1 (memory read), then stage 2 (output register).
// Throughput: one transfer per cycle, set by the one memory read per transfer,
// when not clearing and the output is not stalled. Reset: synchronous, active
// low; then a clearing pass zeroes all 32768 RAM entries one entry a cycle,
// with the input stalled throughout. ROM contents are undefined until loaded.
module handheld_console_memory_map_bus (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  hcmm_pkg::t_op        i_op,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_write_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_read_data,
    output logic                 o_rom_write_warning,
    output logic [31:0]          o_cycle_count
);
    import hcmm_pkg::*;

    localparam int ROM_DEPTH = 1 << ROM_AW;
    localparam int RAM_DEPTH = 1 << RAM_AW;

    // ROM: one fixed 32768-entry array with no bank switching, covering both halves,
    // indexed directly by address bits 14:0. No reset, filled by loads.
    logic [7:0] r_rom [ROM_DEPTH];
    // RAM layout by bits 14:13 of the index: video, external, work, and the
    // top page (sprite table, I/O, high RAM, interrupt enable) by address[8:0].
    logic [7:0] r_ram [RAM_DEPTH];

    logic [7:0] r_rom_q;
    logic [7:0] r_ram_q;

    // clearing pass
    logic              r_clr_busy;
    logic [RAM_AW-1:0] r_clr_idx;

    // cycle total
    logic [31:0] r_cycle;
    logic [31:0] n_cycle;

    // stage 1: memory read in flight
    logic        r_s1_valid;
    t_rsel       r_s1_rsel;
    logic        r_s1_warn;
    logic [31:0] r_s1_count;

    // stage 2: output register
    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_warn;
    logic [31:0] r_out_count;

    logic              in_acc;
    logic              s1_move;
    logic              is_rom;
    logic              is_hole;
    logic [RAM_AW-1:0] ram_idx;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              rom_we;
    t_rsel             rsel;
    logic              warn;
    logic [7:0]        s1_data;

    // --- decode -----------------------------------------------------------
    assign is_rom      = ~i_address[15];
    assign is_hole     = (i_address >= ADDR_HOLE_LO) && (i_address < ADDR_IO_LO);

    always_comb begin
        ram_idx = '0;
        case (i_address[15:13])
            3'b100: ram_idx = {2'd0, i_address[12:0]};
            3'b101: ram_idx = {2'd1, i_address[12:0]};
            3'b110: ram_idx = {2'd2, i_address[12:0]};
            3'b111: begin
                // echo of work RAM below the top page
                if (i_address <= ADDR_ECHO_END) begin
                    ram_idx = {2'd2, i_address[12:0]};
                end else begin
                    ram_idx = {2'd3, 4'd0, i_address[8:0]};
                end
            end
            default: ram_idx = '0;
        endcase
    end

    // --- handshake --------------------------------------------------------
    // Advance stage 1 when the output register is empty or being drained;
    // hold the input while clearing or while stage 1 cannot advance.
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_valid && !s1_move);
    assign in_acc     = i_in_valid && !o_in_stall;

    // --- per-transfer actions ---------------------------------------------
    always_comb begin
        rsel    = RSEL_ZERO;
        warn    = 1'b0;
        ram_we  = 1'b0;
        rom_we  = 1'b0;
        n_cycle = r_cycle;
        case (i_op)
            OP_READ: begin
                n_cycle = r_cycle + CYCLES_PER_ACC;
                if (is_rom) begin
                    rsel = RSEL_ROM;
                end else if (is_hole || i_address == ADDR_JOYPAD) begin
                    rsel = RSEL_FF;
                end else begin
                    rsel = RSEL_RAM;
                end
            end
            OP_WRITE: begin
                n_cycle = r_cycle + CYCLES_PER_ACC;
                if (is_rom) begin
                    warn = 1'b1;
                end else if (!is_hole) begin
                    ram_we = 1'b1;
                end
            end
            OP_LOAD: begin
                rom_we = is_rom;
            end
            default: begin
                n_cycle = r_cycle;
            end
        endcase
    end

    // clearing pass owns the RAM write port until done
    always_comb begin
        if (r_clr_busy) begin
            ram_waddr = r_clr_idx;
            ram_wdata = '0;
        end else begin
            ram_waddr = ram_idx;
            ram_wdata = (i_address == ADDR_DIV) ? 8'd0 : i_write_data;
        end
    end

    // --- memories ---------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc && rom_we) begin
            r_rom[i_address[ROM_AW-1:0]] <= i_write_data;
        end
        if (in_acc) begin
            r_rom_q <= r_rom[i_address[ROM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy || (in_acc && ram_we)) begin
            r_ram[ram_waddr] <= ram_wdata;
        end
        if (in_acc) begin
            r_ram_q <= r_ram[ram_idx];
        end
    end

    // --- control registers ------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (&r_clr_idx) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cycle <= n_cycle;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // --- payload registers ------------------------------------------------
    always_comb begin
        case (r_s1_rsel)
            RSEL_ZERO: s1_data = 8'd0;
            RSEL_FF:   s1_data = BYTE_FF;
            RSEL_ROM:  s1_data = r_rom_q;
            RSEL_RAM:  s1_data = r_ram_q;
            default:   s1_data = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_rsel  <= rsel;
            r_s1_warn  <= warn;
            r_s1_count <= n_cycle;
        end
        if (s1_move) begin
            r_out_data  <= s1_data;
            r_out_warn  <= r_s1_warn;
            r_out_count <= r_s1_count;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_out_data;
    assign o_rom_write_warning = r_out_warn;
    assign o_cycle_count       = r_out_count;

    // --- assertions -------------------------------------------------------
    a_no_accept_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) r_clr_busy |-> o_in_stall)
        else $error("input accepted during clearing pass");

    a_count_step: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_op == OP_READ || i_op == OP_WRITE))
            |=> (r_cycle == $past(r_cycle) + CYCLES_PER_ACC))
        else $error("cycle total did not advance by four");

    a_count_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> (r_cycle == $past(r_cycle)))
        else $error("cycle total changed without a transfer");

    a_warn_no_data: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rom_write_warning) |-> (o_read_data == 8'd0))
        else $error("ROM write warning with nonzero read data");

    a_backpressure: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input taken while stage 1 is blocked");

endmodule
